FILE: rtl/edit_distance_similarity_defines.svh
// ----------------------------------------------------------------------------
// Edit distance similarity assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_SIMILARITY_DEFINES_SVH
`define EDIT_DISTANCE_SIMILARITY_DEFINES_SVH

// same-cycle implication
`define EDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/eds_pkg.sv
// ----------------------------------------------------------------------------
// Edit distance similarity package
// Sizes, status codes, transaction payloads and the DP token type.
// ----------------------------------------------------------------------------
package eds_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int MAX_TEXT    = 4096;

  localparam int CH_W   = 8;
  localparam int DIST_W = 13;
  localparam int SIM_W  = 17;
  localparam int ST_W   = 2;
  localparam int FRAC_W = 16;
  localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
  localparam int PIDX_W = $clog2(MAX_PATTERN);
  localparam int TLEN_W = $clog2(MAX_TEXT + 1);

  localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1) << FRAC_W;

  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] STAT_OVF   = 2'd2;

  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] ch;
    logic            has_char;
    logic            last;
  } eds_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [SIM_W-1:0]  similarity;
    logic [ST_W-1:0]   status;
  } eds_out_t;

  // one text character travelling along the cell row
  typedef struct packed {
    logic              first;
    logic [CH_W-1:0]   ch;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] diag;
  } eds_tok_t;

  function automatic logic [CH_W-1:0] fold_case(input logic [CH_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

FILE: rtl/edit_distance_similarity.sv
// ----------------------------------------------------------------------------
// Edit distance similarity
// Levenshtein distance over a systolic row of DP cells, case-folded ASCII,
// with similarity 1 - d / max(m, n) in unsigned Q1.16.
// ----------------------------------------------------------------------------
//  channel | ports                     | payload
//  input   | in_valid / in_ready       | in_data   (eds_in_t)
//  result  | out_valid / out_ready     | out_data  (eds_out_t)
//
// Pattern and text transactions are taken one per cycle while in_ready is high;
// each text character up to MAX_TEXT enters the cell row in the next cycle and
// moves one cell a cycle. After the last text item the row drains, then the
// divider starts and shifts out the quotient bits, and out_valid rises when it
// is done. in_ready is low from the last text item until the result transaction.
// Reset is synchronous.
// ----------------------------------------------------------------------------
`include "edit_distance_similarity_defines.svh"

module edit_distance_similarity (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  eds_pkg::eds_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output eds_pkg::eds_out_t  out_data
);
  import eds_pkg::*;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_DRAIN = 3'd1;
  localparam logic [2:0] ST_DIVS  = 3'd2;
  localparam logic [2:0] ST_DIVW  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]        state_r;
  logic [PLEN_W-1:0] plen_r;
  logic              loaded_r;
  logic              povf_r;
  logic [TLEN_W-1:0] tlen_r;
  logic              tovf_r;
  logic              inj_vld_r;
  eds_tok_t          inj_r;
  logic [DIST_W-1:0] lng_r;
  logic [DIST_W-1:0] dist_r;
  logic [ST_W-1:0]   stat_r;
  logic              out_vld_r;
  eds_out_t          out_r;

  logic              acc;
  logic              is_pat;
  logic              is_txt;
  logic [CH_W-1:0]   fch;
  logic [PLEN_W-1:0] pbase;
  logic              pwr;
  logic              tchar;
  logic              tok_go;
  logic              drained;

  logic [MAX_PATTERN-1:0] pat_we;
  logic [MAX_PATTERN:0]   vld;
  eds_tok_t               tok [MAX_PATTERN+1];
  logic [DIST_W-1:0]      dp_arr [MAX_PATTERN];

  logic [DIST_W-1:0] n_len;
  logic [DIST_W-1:0] m_len;
  logic [DIST_W-1:0] lng_nxt;
  logic [DIST_W-1:0] draw;
  logic [DIST_W-1:0] dist_nxt;
  logic [DIST_W-1:0] dp_sel;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [SIM_W-1:0]  div_q;

  logic              res_empty;
  logic              res_zero;
  logic              res_exact;

  assign acc    = in_valid && in_ready;
  assign is_pat = acc && !in_data.cmd;
  assign is_txt = acc && in_data.cmd;
  assign fch    = fold_case(in_data.ch);
  assign pbase  = loaded_r ? '0 : plen_r;
  assign pwr    = is_pat && in_data.has_char && (pbase < PLEN_W'(MAX_PATTERN));
  assign tchar  = is_txt && in_data.has_char;
  assign tok_go = tchar && (tlen_r < TLEN_W'(MAX_TEXT));

  // cell row
  assign vld[0] = inj_vld_r;
  assign tok[0] = inj_r;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    assign pat_we[j] = pwr && (pbase == PLEN_W'(j));
    eds_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .pat_we (pat_we[j]),
      .pat_ch (fch),
      .vld_i  (vld[j]),
      .tok_i  (tok[j]),
      .vld_o  (vld[j+1]),
      .tok_o  (tok[j+1]),
      .dp_o   (dp_arr[j])
    );
  end

  assign drained = ~|vld;

  // result of the row
  assign n_len    = DIST_W'(tlen_r);
  assign m_len    = DIST_W'(plen_r);
  assign lng_nxt  = (m_len > n_len) ? m_len : n_len;
  assign dp_sel   = dp_arr[PIDX_W'(plen_r - PLEN_W'(1))];
  assign draw     = (n_len == '0) ? m_len : ((plen_r == '0) ? n_len : dp_sel);
  assign dist_nxt = (draw > lng_nxt) ? lng_nxt : draw;

  assign div_start = (state_r == ST_DIVS);

  eds_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .den_i   (lng_r),
    .dist_i  (dist_r),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      plen_r    <= '0;
      loaded_r  <= 1'b0;
      povf_r    <= 1'b0;
      tlen_r    <= '0;
      tovf_r    <= 1'b0;
      inj_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      inj_vld_r <= tok_go;
      case (state_r)
        ST_RUN: begin
          if (is_pat) begin
            tlen_r   <= '0;
            tovf_r   <= 1'b0;
            loaded_r <= in_data.last;
            if (pwr) begin
              plen_r <= pbase + PLEN_W'(1);
            end else begin
              plen_r <= pbase;
            end
            if (in_data.has_char && !pwr) begin
              povf_r <= 1'b1;
            end else if (loaded_r) begin
              povf_r <= 1'b0;
            end
          end else if (is_txt) begin
            loaded_r <= 1'b1;
            if (tok_go) begin
              tlen_r <= tlen_r + TLEN_W'(1);
            end else if (tchar) begin
              tovf_r <= 1'b1;
            end
            if (in_data.last) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (drained) begin
            tlen_r  <= '0;
            tovf_r  <= 1'b0;
            state_r <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            out_vld_r <= 1'b1;
            state_r   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_vld_r <= 1'b0;
            state_r   <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tok_go) begin
      inj_r.first <= (tlen_r == '0);
      inj_r.ch    <= fch;
      inj_r.left  <= DIST_W'(tlen_r + TLEN_W'(1));
      inj_r.diag  <= DIST_W'(tlen_r);
    end
    if (state_r == ST_DRAIN && drained) begin
      lng_r  <= lng_nxt;
      dist_r <= dist_nxt;
      if (lng_nxt == '0) begin
        stat_r <= STAT_EMPTY;
      end else if (povf_r || tovf_r) begin
        stat_r <= STAT_OVF;
      end else begin
        stat_r <= STAT_OK;
      end
    end
    if (state_r == ST_DIVW && div_done) begin
      out_r.distance   <= dist_r;
      out_r.similarity <= (stat_r == STAT_EMPTY) ? '0 : div_q;
      out_r.status     <= stat_r;
    end
  end

  assign in_ready  = (state_r == ST_RUN);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign res_empty = out_valid && (out_data.status == STAT_EMPTY);
  assign res_zero  = (out_data.similarity == '0) && (out_data.distance == '0);
  assign res_exact = out_valid && (out_data.status != STAT_EMPTY) && (out_data.distance == '0);

  `EDS_ASSERT_IMP(a_rdy_excl, in_ready, !out_valid, "input open while result pending")
  `EDS_ASSERT_NXT(a_last_stop, is_txt && in_data.last, !in_ready, "input open after text end")
  `EDS_ASSERT_IMP(a_div_idle, state_r == ST_RUN, !div_busy, "divider busy while running")
  `EDS_ASSERT_IMP(a_empty_res, res_empty, res_zero, "empty result not zero")
  `EDS_ASSERT_IMP(a_exact, res_exact, out_data.similarity == SIM_ONE, "exact match not one")

endmodule

FILE: rtl/eds_cell.sv
// ----------------------------------------------------------------------------
// Edit distance DP cell
// Holds one pattern character and one DP column; updates it as a token passes.
// ----------------------------------------------------------------------------
module eds_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pat_we,
  input  logic [eds_pkg::CH_W-1:0]      pat_ch,
  input  logic                          vld_i,
  input  eds_pkg::eds_tok_t             tok_i,
  output logic                          vld_o,
  output eds_pkg::eds_tok_t             tok_o,
  output logic [eds_pkg::DIST_W-1:0]    dp_o
);
  import eds_pkg::*;

  logic [CH_W-1:0]   pch_r;
  logic [DIST_W-1:0] dp_r;
  logic              vld_r;
  eds_tok_t          tok_r;

  logic [DIST_W-1:0] up;
  logic [DIST_W-1:0] c_up;
  logic [DIST_W-1:0] c_left;
  logic [DIST_W-1:0] c_sub;
  logic [DIST_W-1:0] m_a;
  logic [DIST_W-1:0] dp_nxt;
  logic              mis;

  // a first token carries the initial row: own old value is left old + 1
  assign up     = tok_i.first ? tok_i.diag + DIST_W'(1) : dp_r;
  assign mis    = (pch_r != tok_i.ch);
  assign c_up   = up + DIST_W'(1);
  assign c_left = tok_i.left + DIST_W'(1);
  assign c_sub  = tok_i.diag + {{(DIST_W-1){1'b0}}, mis};
  assign m_a    = (c_up < c_left) ? c_up : c_left;
  assign dp_nxt = (m_a < c_sub) ? m_a : c_sub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pch_r <= pat_ch;
    end
    if (vld_i) begin
      dp_r       <= dp_nxt;
      tok_r.first <= tok_i.first;
      tok_r.ch    <= tok_i.ch;
      tok_r.left  <= dp_nxt;
      tok_r.diag  <= up;
    end
  end

  assign vld_o = vld_r;
  assign tok_o = tok_r;
  assign dp_o  = dp_r;

endmodule

FILE: rtl/eds_div.sv
// ----------------------------------------------------------------------------
// Edit distance similarity divider
// Restoring divider, one quotient bit a cycle: ((L - d) << 16) / L.
// ----------------------------------------------------------------------------
`include "edit_distance_similarity_defines.svh"

module eds_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [eds_pkg::DIST_W-1:0]    den_i,
  input  logic [eds_pkg::DIST_W-1:0]    dist_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [eds_pkg::SIM_W-1:0]     q_o
);
  import eds_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIST_W-1:0] rem_r;
  logic [DIST_W-1:0] den_r;
  logic [SIM_W-1:0]  q_r;

  logic [DIST_W:0]   r2;
  logic [DIST_W:0]   diff;
  logic              ge;

  assign r2   = {rem_r, 1'b0};
  assign diff = r2 - {1'b0, den_r};
  assign ge   = (r2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRAC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      den_r <= den_i;
      q_r   <= SIM_W'(dist_i == '0);
      rem_r <= (dist_i == '0) ? '0 : den_i - dist_i;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIST_W-1:0] : r2[DIST_W-1:0];
      q_r   <= {q_r[SIM_W-2:0], ge};
    end
  end

  assign busy_o = busy_r;
  assign done_o = done_r;
  assign q_o    = q_r;

  `EDS_ASSERT_NXT(a_div_start, start_i, busy_r, "divider did not start")
  `EDS_ASSERT_IMP(a_div_nostart, busy_r, !start_i, "divider restarted while busy")
  `EDS_ASSERT_IMP(a_div_done, done_r, !busy_r, "divider done while busy")

endmodule
